[src/ssrp_pkg.sv]
// ----------------------------------------------------------------------------
// ssrp_pkg
// Shared types, codes and constants of the shortest-seek request picker.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrp_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int SECTOR_W      = 16;
	localparam int LIMIT_W       = 5;
	localparam int COUNT_W       = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	function automatic logic [SECTOR_W-1:0] seek_dist(
		input logic [SECTOR_W-1:0] a,
		input logic [SECTOR_W-1:0] b
	);
		seek_dist = (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

[src/ssrp_store.sv]
// ----------------------------------------------------------------------------
// ssrp_store
// Sector store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrp_store #(
	parameter int DEPTH = ssrp_pkg::DEPTH_DEFAULT,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 waddr,
	input  wire logic [ssrp_pkg::SECTOR_W-1:0] wdata,
	input  wire logic [AW-1:0]                 raddr,
	output logic      [ssrp_pkg::SECTOR_W-1:0] rdata
);

	logic [ssrp_pkg::SECTOR_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[src/shortest_seek_request_picker_unit.sv]
// ----------------------------------------------------------------------------
// shortest_seek_request_picker_unit
// Pending-request store with nearest-sector dequeue, arrival-order tie break.
// ----------------------------------------------------------------------------
// One item is in work at a time. Enqueue, full and empty items go straight
// to the finish step. A dequeue reads the store one entry per cycle to find
// the nearest sector, then moves the entries behind the chosen one down one
// place, one per cycle, through the single read and write port of the
// sector memory. A finished result waits in the output register while the
// next item is taken in.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_seek_request_picker_unit #(
	parameter int DEPTH = ssrp_pkg::DEPTH_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [ssrp_pkg::LIMIT_W-1:0]  cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          opcode,
	input  wire logic [ssrp_pkg::SECTOR_W-1:0] request_sector,
	input  wire logic [ssrp_pkg::SECTOR_W-1:0] arm_position,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [ssrp_pkg::SECTOR_W-1:0] chosen_sector,
	output logic      [1:0]                    status,
	output logic      [ssrp_pkg::COUNT_W-1:0]  pending_count
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int PCW = ssrp_pkg::COUNT_W;
	localparam int SW  = ssrp_pkg::SECTOR_W;

	ssrp_pkg::state_t  state_q, state_d;
	ssrp_pkg::status_t res_status_q, out_status_q;

	logic [CW-1:0]                  count_q;
	logic [ssrp_pkg::LIMIT_W-1:0]   limit_q;
	logic                           out_valid_q;
	logic [SW-1:0]                  arm_q;
	logic [AW-1:0]                  cidx_q, widx_q, best_idx_q;
	logic [SW-1:0]                  best_dist_q;
	logic [SW-1:0]                  res_sector_q, out_sector_q;
	logic [PCW-1:0]                 out_count_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [SW-1:0] mem_wdata, mem_rdata;

	logic          in_xfer, full, empty, out_free;
	logic [AW-1:0] last_idx, new_best_idx;
	logic [SW-1:0] cur_dist;
	logic          take, scan_last, shift_last;

	assign in_xfer    = in_valid && in_ready;
	assign full       = (32'(count_q) >= 32'(limit_q)) || (32'(count_q) >= DEPTH);
	assign empty      = (count_q == '0);
	assign out_free   = !out_valid_q || out_ready;
	assign last_idx   = AW'(count_q - CW'(1));
	assign cur_dist   = ssrp_pkg::seek_dist(mem_rdata, arm_q);
	assign take       = (cidx_q == '0) || (cur_dist < best_dist_q);
	assign new_best_idx = take ? cidx_q : best_idx_q;
	assign scan_last  = (cidx_q == last_idx);
	assign shift_last = (widx_q == last_idx);

	ssrp_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssrp_pkg::S_IDLE: begin
				if (in_xfer) begin
					if (opcode == ssrp_pkg::OP_DEQ && !empty) begin
						state_d = ssrp_pkg::S_SCAN;
					end else begin
						state_d = ssrp_pkg::S_FINISH;
					end
				end
			end
			ssrp_pkg::S_SCAN: begin
				if (scan_last) begin
					state_d = ssrp_pkg::S_SHIFT;
				end
			end
			ssrp_pkg::S_SHIFT: begin
				if (shift_last) begin
					state_d = ssrp_pkg::S_FINISH;
				end
			end
			ssrp_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = ssrp_pkg::S_IDLE;
				end
			end
			default: state_d = ssrp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = widx_q;
		mem_wdata = mem_rdata;
		mem_raddr = '0;
		case (state_q)
			ssrp_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				mem_we    = in_xfer && opcode == ssrp_pkg::OP_ENQ && !full;
				mem_waddr = count_q[AW-1:0];
				mem_wdata = request_sector;
			end
			ssrp_pkg::S_SCAN: begin
				mem_raddr = scan_last ? AW'(new_best_idx + AW'(1)) : AW'(cidx_q + AW'(1));
			end
			ssrp_pkg::S_SHIFT: begin
				mem_we    = !shift_last;
				mem_raddr = AW'(widx_q + AW'(2));
			end
			default: begin
				mem_raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssrp_pkg::S_IDLE;
			count_q     <= '0;
			limit_q     <= ssrp_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (state_q == ssrp_pkg::S_IDLE && in_xfer
					&& opcode == ssrp_pkg::OP_ENQ && !full) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == ssrp_pkg::S_SHIFT && shift_last) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == ssrp_pkg::S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ssrp_pkg::S_IDLE: begin
				if (in_xfer) begin
					arm_q        <= arm_position;
					cidx_q       <= '0;
					res_sector_q <= '0;
					if (opcode == ssrp_pkg::OP_ENQ) begin
						res_status_q <= full ? ssrp_pkg::ST_FULL : ssrp_pkg::ST_ENQUEUED;
					end else begin
						res_status_q <= empty ? ssrp_pkg::ST_EMPTY : ssrp_pkg::ST_DEQUEUED;
					end
				end
			end
			ssrp_pkg::S_SCAN: begin
				if (take) begin
					best_idx_q   <= cidx_q;
					best_dist_q  <= cur_dist;
					res_sector_q <= mem_rdata;
				end
				cidx_q <= AW'(cidx_q + AW'(1));
				widx_q <= new_best_idx;
			end
			ssrp_pkg::S_SHIFT: begin
				widx_q <= AW'(widx_q + AW'(1));
			end
			ssrp_pkg::S_FINISH: begin
				if (out_free) begin
					out_sector_q <= res_sector_q;
					out_status_q <= res_status_q;
					out_count_q  <= PCW'(count_q);
				end
			end
			default: begin
				cidx_q <= '0;
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign chosen_sector = out_sector_q;
	assign status        = out_status_q;
	assign pending_count = out_count_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q != ssrp_pkg::S_IDLE)
		else $error("state stayed idle after an input transfer");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ssrp_pkg::S_FINISH)
		else $error("result raised outside the finish step");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
		else $error("entry count moved by more than one");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssrp_pkg::S_SCAN |-> 32'(cidx_q) < 32'(count_q))
		else $error("scan index beyond stored entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssrp_pkg::S_SHIFT |-> 32'(widx_q) < 32'(count_q))
		else $error("shift index beyond stored entries");

endmodule

`default_nettype wire
